FILE: design/htfr_pkg.sv
// Shared types and constants for the header/trailer frame receiver.
`timescale 1ns / 1ps

package htfr_pkg;

  localparam int NUM_VALUES = 7;

  // Configuration register indexes
  localparam logic CFG_HEADER  = 1'b0;
  localparam logic CFG_TRAILER = 1'b1;

  localparam logic [7:0] HEADER_RESET  = 8'h0D;
  localparam logic [7:0] TRAILER_RESET = 8'h0A;

  typedef enum logic [2:0] {
    ST_STRAY   = 3'd0,
    ST_HEADER  = 3'd1,
    ST_PAYLOAD = 3'd2,
    ST_DONE    = 3'd3,
    ST_BAD     = 3'd4
  } status_t;

  typedef struct packed {
    status_t                        status;
    logic [NUM_VALUES-1:0][7:0]     values;
    logic [7:0]                     stray_count;
  } result_t;

endpackage

FILE: design/htfr_rx_if.sv
// Request channel carrying one received byte.
`timescale 1ns / 1ps

interface htfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: design/htfr_res_if.sv
// Result channel: status, payload registers and stray count.
`timescale 1ns / 1ps

interface htfr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] value_one;
  logic [7:0] value_two;
  logic [7:0] value_three;
  logic [7:0] value_four;
  logic [7:0] value_five;
  logic [7:0] value_six;
  logic [7:0] value_seven;
  logic [7:0] stray_count;

  modport source (
    output valid, output status, output value_one, output value_two,
    output value_three, output value_four, output value_five, output value_six,
    output value_seven, output stray_count, input ready
  );
  modport sink (
    input valid, input status, input value_one, input value_two,
    input value_three, input value_four, input value_five, input value_six,
    input value_seven, input stray_count, output ready
  );
endinterface

FILE: design/htfr_stray_mem.sv
// Stray byte buffer, written at the running stray count.
`timescale 1ns / 1ps

module htfr_stray_mem #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= data;
    end
  end

endmodule

FILE: design/htfr_deframer.sv
// Frame state and next-state logic for one received byte.
`timescale 1ns / 1ps

module htfr_deframer
  import htfr_pkg::*;
#(
  parameter int PAYLOAD_LEN = 7,
  parameter int STRAY_DEPTH = 256,
  localparam int FILL_W = (STRAY_DEPTH > 1) ? $clog2(STRAY_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        header_byte,
  input  logic [7:0]        trailer_byte,
  output result_t           result,
  output logic              stray_we,
  output logic [FILL_W-1:0] stray_addr,
  output logic [7:0]        stray_data
);

  logic                       in_frame;
  logic                       in_frame_next;
  logic [2:0]                 payload_index;
  logic [2:0]                 payload_index_next;
  logic [NUM_VALUES-1:0][7:0] values;
  logic [NUM_VALUES-1:0][7:0] values_next;
  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          fill_next;
  logic [FILL_W+7:0]          fill_ext;
  logic                       stray_hit;
  status_t                    status;

  always_comb begin
    in_frame_next      = in_frame;
    payload_index_next = payload_index;
    values_next        = values;
    fill_next          = fill;
    stray_hit          = 1'b0;
    status             = ST_STRAY;
    if (in_frame) begin
      // position decides inside a frame; header value is not special here
      if (payload_index < 3'(PAYLOAD_LEN)) begin
        for (int k = 0; k < NUM_VALUES; k++) begin
          if (payload_index == 3'(k)) begin
            values_next[k] = rx_byte;
          end
        end
        payload_index_next = 3'(payload_index + 3'd1);
        status             = ST_PAYLOAD;
      end else if (rx_byte == trailer_byte) begin
        in_frame_next      = 1'b0;
        payload_index_next = '0;
        status             = ST_DONE;
      end else begin
        in_frame_next      = 1'b0;
        payload_index_next = '0;
        fill_next          = '0;
        status             = ST_BAD;
      end
    end else if (rx_byte == header_byte) begin
      in_frame_next = 1'b1;
      status        = ST_HEADER;
    end else begin
      stray_hit = 1'b1;
      if (fill == FILL_W'(STRAY_DEPTH - 1)) begin
        fill_next = '0;
      end else begin
        fill_next = FILL_W'(fill + 1'b1);
      end
      status = ST_STRAY;
    end
  end

  // low byte of the count, zero-extended when the buffer is small
  assign fill_ext = {8'b0, fill_next};

  always_comb begin
    result.status      = status;
    result.values      = values_next;
    result.stray_count = fill_ext[7:0];
  end

  assign stray_we   = step && stray_hit;
  assign stray_addr = fill;
  assign stray_data = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      payload_index <= '0;
      values        <= '0;
      fill          <= '0;
    end else if (step) begin
      in_frame      <= in_frame_next;
      payload_index <= payload_index_next;
      values        <= values_next;
      fill          <= fill_next;
    end
  end

endmodule

FILE: design/header_trailer_frame_receiver_top.sv
// Top level of the header/trailer frame receiver.
`timescale 1ns / 1ps

// Deframes a serial byte stream into fixed-length frames.
// rx:  one received byte per request (valid/ready).
// res: one result per byte: status, the seven payload registers as they
//      stand after that byte, and the low byte of the stray count.
// Config: cfg_write with cfg_index 0 sets the header byte, 1 the trailer.
//      Write only while no byte is in flight.
// Flow: an accepted byte is held in the input register; its result is
//      loaded into the result register and is offered from then on.
//      Throughput is one byte per cycle while res is not held off; the
//      frame update between the input and result registers is combinational.
// Stall: while res is held off the result stays put; one more byte waits
//      in the input register, then rx.ready drops.
// Reset: header 0x0D, trailer 0x0A, outside a frame, payload registers and
//      stray count zero, both channels empty. Stray buffer contents are
//      undefined until written.
module header_trailer_frame_receiver_top
  import htfr_pkg::*;
#(
  parameter int PAYLOAD_LEN = 7,
  parameter int STRAY_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  htfr_rx_if.sink    rx,
  htfr_res_if.source res
);

  localparam int FILL_W = (STRAY_DEPTH > 1) ? $clog2(STRAY_DEPTH) : 1;

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_valid;
  result_t           out_res;
  result_t           result;
  logic              advance;
  logic              step;
  logic [7:0]        header_byte;
  logic [7:0]        trailer_byte;
  logic              stray_we;
  logic [FILL_W-1:0] stray_addr;
  logic [7:0]        stray_data;

  assign advance  = !out_valid || res.ready;
  assign step     = in_valid && advance;
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= HEADER_RESET;
      trailer_byte <= TRAILER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HEADER:  header_byte  <= cfg_data;
        CFG_TRAILER: trailer_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rx.ready) begin
        in_valid <= rx.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
    if (step) begin
      out_res <= result;
    end
  end

  htfr_deframer #(
    .PAYLOAD_LEN (PAYLOAD_LEN),
    .STRAY_DEPTH (STRAY_DEPTH)
  ) u_deframer (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (in_byte),
    .header_byte  (header_byte),
    .trailer_byte (trailer_byte),
    .result       (result),
    .stray_we     (stray_we),
    .stray_addr   (stray_addr),
    .stray_data   (stray_data)
  );

  htfr_stray_mem #(
    .DEPTH (STRAY_DEPTH)
  ) u_stray_mem (
    .clk  (clk),
    .we   (stray_we),
    .addr (stray_addr),
    .data (stray_data)
  );

  assign res.valid       = out_valid;
  assign res.status      = out_res.status;
  assign res.value_one   = out_res.values[0];
  assign res.value_two   = out_res.values[1];
  assign res.value_three = out_res.values[2];
  assign res.value_four  = out_res.values[3];
  assign res.value_five  = out_res.values[4];
  assign res.value_six   = out_res.values[5];
  assign res.value_seven = out_res.values[6];
  assign res.stray_count = out_res.stray_count;

endmodule

FILE: test/htfr_frame_checker.sv
// Result checker for the header/trailer frame receiver: predicts and compares each result.
`timescale 1ns / 1ps

module htfr_frame_checker
  import htfr_pkg::*;
#(
  parameter int PAYLOAD_LEN = 7,
  parameter int STRAY_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  htfr_rx_if         rx,
  htfr_res_if        res,
  output int         fail_count,
  output int         pending
);

  localparam int REPORT_CAP = 100;

  logic [7:0] header_cfg;
  logic [7:0] trailer_cfg;
  logic       frame_open;
  int         taken;
  logic [7:0] payload_regs [NUM_VALUES];
  int         stray_level;
  int         mismatches;
  result_t    results_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  // Stray buffer is write-only as seen from the ports, so only its fill level is kept.
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    if (frame_open) begin
      if (taken < PAYLOAD_LEN) begin
        payload_regs[taken] = b;
        taken++;
        r.status = ST_PAYLOAD;
      end else if (b == trailer_cfg) begin
        frame_open = 1'b0;
        taken      = 0;
        r.status   = ST_DONE;
      end else begin
        frame_open  = 1'b0;
        taken       = 0;
        stray_level = 0;
        r.status    = ST_BAD;
      end
    end else if (b == header_cfg) begin
      frame_open = 1'b1;
      r.status   = ST_HEADER;
    end else begin
      stray_level = (stray_level + 1) % STRAY_DEPTH;
      r.status    = ST_STRAY;
    end
    for (int k = 0; k < NUM_VALUES; k++) r.values[k] = payload_regs[k];
    r.stray_count = stray_level[7:0];
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
    if (mismatches < REPORT_CAP)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t    want;
    logic [7:0] got [NUM_VALUES];
    if (rst) begin
      header_cfg  = HEADER_RESET;
      trailer_cfg = TRAILER_RESET;
      frame_open  = 1'b0;
      taken       = 0;
      stray_level = 0;
      for (int k = 0; k < NUM_VALUES; k++) payload_regs[k] = 8'h00;
      results_due.delete();
    end else begin
      if (res.valid && res.ready) begin
        got[0] = res.value_one;
        got[1] = res.value_two;
        got[2] = res.value_three;
        got[3] = res.value_four;
        got[4] = res.value_five;
        got[5] = res.value_six;
        got[6] = res.value_seven;
        if (results_due.size() == 0) begin
          if (mismatches < REPORT_CAP)
            $display("%0t: result with no request pending, expected none, actual status %0d",
                     $time, res.status);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (res.status !== want.status)
            note_mismatch("status", 8'(want.status), 8'(res.status));
          for (int k = 0; k < NUM_VALUES; k++)
            if (got[k] !== want.values[k])
              note_mismatch($sformatf("value %0d", k + 1), want.values[k], got[k]);
          if (res.stray_count !== want.stray_count)
            note_mismatch("stray_count", want.stray_count, res.stray_count);
        end
      end
      if (rx.valid && rx.ready) results_due.push_back(deframe_byte(rx.rx_byte));
      if (cfg_write) begin
        if (cfg_index == CFG_HEADER) header_cfg = cfg_data;
        else trailer_cfg = cfg_data;
      end
    end
    fail_count <= mismatches;
    pending    <= results_due.size();
  end

endmodule

FILE: test/header_trailer_frame_receiver_top_tb.sv
// Testbench top for the header/trailer frame receiver: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module header_trailer_frame_receiver_top_tb
  import htfr_pkg::*;
();

  localparam int PAYLOAD_LEN = 7;
  localparam int STRAY_DEPTH = 256;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 270;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       calm;
  logic       hold_req;
  int         fail_count;
  int         pending;
  int         sent;
  logic [7:0] hdr;
  logic [7:0] trl;

  htfr_rx_if  rx_ch ();
  htfr_res_if res_ch ();

  header_trailer_frame_receiver_top #(
    .PAYLOAD_LEN(PAYLOAD_LEN),
    .STRAY_DEPTH(STRAY_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rx(rx_ch),
    .res(res_ch)
  );

  htfr_frame_checker #(
    .PAYLOAD_LEN(PAYLOAD_LEN),
    .STRAY_DEPTH(STRAY_DEPTH)
  ) frame_checker (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rx(rx_ch),
    .res(res_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts, one long hold-off on request, none once calm.
  initial begin
    int  burst_left;
    int  hold_left;
    bit  stalling;
    bit  hold_taken;
    burst_left = 0;
    hold_left  = 0;
    stalling   = 1'b0;
    hold_taken = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        if (burst_left == 0) begin
          stalling   = ($urandom_range(0, 3) == 0);
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        res_ch.ready <= !stalling;
      end
    end
  end

  // Watchdog: too many cycles without any handshake ends the run.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) break;
    end
    $display("header_trailer_frame_receiver_top_tb: FAIL");
    $finish;
  end

  // Offer one byte, after an optional idle burst; returns at the accepting edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sent++;
  endtask

  // Header, random payload, then a correct or a wrong trailer.
  task automatic send_frame(input bit good);
    send_byte(hdr);
    repeat (PAYLOAD_LEN) send_byte(8'($urandom_range(0, 255)));
    if (good) send_byte(trl);
    else send_byte(trl ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic run_random(input int budget);
    int stop;
    int pick;
    stop = sent + budget;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(1'b1);
      end else if (pick < 75) begin
        send_frame(1'b0);
      end else if (pick < 82) begin
        // cut-off frame: following bytes land in the payload
        send_byte(hdr);
        repeat ($urandom_range(0, PAYLOAD_LEN - 1)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_framing(input logic [7:0] h, input logic [7:0] t);
    cfg_write <= 1'b1;
    cfg_index <= CFG_HEADER;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_TRAILER;
    cfg_data  <= t;
    @(posedge clk);
    cfg_write <= 1'b0;
    hdr = h;
    trl = t;
  endtask

  initial begin
    logic [7:0] directed [$];
    logic [7:0] b;
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= CFG_HEADER;
    cfg_data      <= 8'h00;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    calm          <= 1'b0;
    hold_req      <= 1'b0;
    sent = 0;
    hdr  = HEADER_RESET;
    trl  = TRAILER_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // strays, a good frame carrying header and trailer values, a bad frame,
    // then a trailer value outside a frame
    directed = '{8'h00, 8'hFF, 8'h0D,
                 8'h00, 8'hFF, 8'h0D, 8'h0A, 8'h55, 8'hAA, 8'h80, 8'h0A,
                 8'h0D, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h0B,
                 8'h7F, 8'h0A};
    foreach (directed[i]) send_byte(directed[i]);

    // long stray run so the count wraps
    repeat (300) begin
      do b = 8'($urandom_range(0, 255)); while (b == hdr);
      send_byte(b);
    end

    hold_req <= 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    set_framing(8'h00, 8'hFF);
    run_random(PHASE_ITEMS);
    drain();

    set_framing(8'hFF, 8'h00);
    run_random(PHASE_ITEMS);
    drain();

    // header and trailer share one value
    set_framing(8'h5A, 8'h5A);
    run_random(PHASE_ITEMS);
    drain();

    set_framing(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    calm <= 1'b1;
    run_random(PHASE_ITEMS);
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("header_trailer_frame_receiver_top_tb: PASS");
    end else begin
      $display("header_trailer_frame_receiver_top_tb: FAIL");
    end
    $finish;
  end

endmodule
